// ===== hdl/gbfp_pkg.sv =====
`timescale 1ns / 1ps

package gbfp_pkg;

	localparam int MAX_PAYLOAD = 512;
	localparam int ADDR_W = $clog2(MAX_PAYLOAD);
	localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

	localparam logic [7:0] SYNC_FIRST = 8'hB5;
	localparam logic [7:0] SYNC_SECOND = 8'h62;
	localparam logic [7:0] SAT_CLASS = 8'h01;
	localparam logic [7:0] SAT_ID = 8'h35;
	localparam int SAT_HDR_LEN = 8;
	localparam int SAT_REC_LEN = 12;
	localparam int SAT_COUNT_POS = 5;
	localparam int SAT_SIGNAL_POS = 2;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_SAT     = 3'd1,
		EV_OTHER   = 3'd2,
		EV_CKFAIL  = 3'd3,
		EV_ABANDON = 3'd4
	} event_t;

	typedef enum logic [3:0] {
		PH_HUNT    = 4'd0,
		PH_SYNC2   = 4'd1,
		PH_CLASS   = 4'd2,
		PH_ID      = 4'd3,
		PH_LEN_LO  = 4'd4,
		PH_LEN_HI  = 4'd5,
		PH_PAYLOAD = 4'd6,
		PH_CK_A    = 4'd7,
		PH_CK_B    = 4'd8
	} phase_t;

	typedef enum logic [2:0] {
		WK_IDLE,
		WK_RD_COUNT,
		WK_GET_COUNT,
		WK_CHECK,
		WK_ACC
	} walk_state_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} store_wr_t;

	typedef struct packed {
		logic [31:0] frames_seen;
		logic [7:0]  sats_reported;
		logic [7:0]  sats_with_signal;
		logic [7:0]  best_signal;
	} summary_t;

endpackage

// ===== hdl/gbfp_in_if.sv =====
`timescale 1ns / 1ps

interface gbfp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

// ===== hdl/gbfp_out_if.sv =====
`timescale 1ns / 1ps

interface gbfp_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_res;
	logic [7:0]  frame_class;
	logic [7:0]  frame_id;
	logic [31:0] sat_frames_seen;
	logic [7:0]  sats_reported;
	logic [7:0]  sats_with_signal;
	logic [7:0]  best_signal;

	modport source(output valid, output event_res, output frame_class, output frame_id,
		output sat_frames_seen, output sats_reported, output sats_with_signal,
		output best_signal, input ready);
	modport sink(input valid, input event_res, input frame_class, input frame_id,
		input sat_frames_seen, input sats_reported, input sats_with_signal,
		input best_signal, output ready);
endinterface

// ===== hdl/gbfp_walk.sv =====
`timescale 1ns / 1ps

module gbfp_walk (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gbfp_pkg::store_wr_t           wr,
	input  logic                          start,
	input  logic [gbfp_pkg::LEN_W-1:0]    frame_len,
	output logic                          busy,
	output logic                          done,
	output gbfp_pkg::summary_t            summary
);
	import gbfp_pkg::*;

	logic [7:0] mem [MAX_PAYLOAD];
	logic [7:0] rd_data_q;
	logic [ADDR_W-1:0] rd_addr;

	walk_state_t state_q, state_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [LEN_W-1:0] offset_q, offset_d;
	logic [7:0] idx_q, idx_d;
	summary_t sum_q, sum_d;
	logic [LEN_W:0] rec_end;

	// Payload store: one write port from the framer, one registered read port for the walk.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rec_end = {1'b0, offset_q} + (LEN_W+1)'(SAT_REC_LEN);

	always_comb begin
		state_d = state_q;
		len_d = len_q;
		offset_d = offset_q;
		idx_d = idx_q;
		sum_d = sum_q;
		done = 1'b0;
		rd_addr = ADDR_W'(offset_q + LEN_W'(SAT_SIGNAL_POS));
		case (state_q)
			WK_IDLE: begin
				if (start) begin
					len_d = frame_len;
					sum_d.frames_seen = sum_q.frames_seen + 32'd1;
					state_d = WK_RD_COUNT;
				end
			end
			WK_RD_COUNT: begin
				rd_addr = ADDR_W'(SAT_COUNT_POS);
				state_d = WK_GET_COUNT;
			end
			WK_GET_COUNT: begin
				sum_d.sats_reported = rd_data_q;
				sum_d.sats_with_signal = 8'd0;
				sum_d.best_signal = 8'd0;
				offset_d = LEN_W'(SAT_HDR_LEN);
				idx_d = 8'd0;
				state_d = WK_CHECK;
			end
			WK_CHECK: begin
				// The read of the signal byte is issued here whether or not the record is taken.
				if (idx_q < sum_q.sats_reported && rec_end <= {1'b0, len_q}) begin
					state_d = WK_ACC;
				end else begin
					done = 1'b1;
					state_d = WK_IDLE;
				end
			end
			WK_ACC: begin
				if (rd_data_q != 8'd0) begin
					sum_d.sats_with_signal = sum_q.sats_with_signal + 8'd1;
				end
				if (rd_data_q > sum_q.best_signal) begin
					sum_d.best_signal = rd_data_q;
				end
				offset_d = offset_q + LEN_W'(SAT_REC_LEN);
				idx_d = idx_q + 8'd1;
				state_d = WK_CHECK;
			end
			default: begin
				state_d = WK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= WK_IDLE;
			len_q <= '0;
			offset_q <= '0;
			idx_q <= '0;
			sum_q <= '0;
		end else begin
			state_q <= state_d;
			len_q <= len_d;
			offset_q <= offset_d;
			idx_q <= idx_d;
			sum_q <= sum_d;
		end
	end

	assign busy = (state_q != WK_IDLE);
	assign summary = sum_q;

endmodule

// ===== hdl/gnss_binary_frame_parser.sv =====
`timescale 1ns / 1ps
// The result of a byte is registered and shown in the cycle after the byte is accepted;
// the closing byte of a satellite frame is answered after its record walk.
// Throughput: one byte a cycle while results are taken; the closing byte of a satellite
// frame starts a record walk over the payload store for N records (N at most 42), with one
// store read per record, checked for nonzero and against the best; no byte is taken meanwhile.
// Reset clears the parser phase, sums, counts and summary; the payload store is not cleared.
module gnss_binary_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	gbfp_in_if.sink     rx_ch,
	gbfp_out_if.source  res_ch
);
	import gbfp_pkg::*;

	phase_t phase_q, phase_d;
	logic [7:0] class_q, class_d;
	logic [7:0] id_q, id_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [LEN_W-1:0] pos_q, pos_d;
	logic [7:0] suma_q, suma_d;
	logic [7:0] sumb_q, sumb_d;

	logic out_valid_q;
	event_t out_event_q, ev;
	logic [7:0] out_class_q, out_id_q, ev_class, ev_id;

	logic accept;
	logic walk_start, walk_busy, walk_done;
	store_wr_t wr;
	summary_t summary;
	logic [7:0] a_next, b_next;
	logic [15:0] new_len;
	logic [LEN_W-1:0] pos_inc;

	assign rx_ch.ready = !walk_busy && (!out_valid_q || res_ch.ready);
	assign accept = rx_ch.valid && rx_ch.ready;

	assign a_next = suma_q + rx_ch.rx_byte;
	assign b_next = sumb_q + a_next;
	assign new_len = {rx_ch.rx_byte, len_q[7:0]};
	assign pos_inc = pos_q + LEN_W'(1);

	always_comb begin
		phase_d = phase_q;
		class_d = class_q;
		id_d = id_q;
		len_d = len_q;
		pos_d = pos_q;
		suma_d = suma_q;
		sumb_d = sumb_q;
		ev = EV_NONE;
		ev_class = 8'd0;
		ev_id = 8'd0;
		walk_start = 1'b0;
		wr.en = 1'b0;
		wr.addr = pos_q[ADDR_W-1:0];
		wr.data = rx_ch.rx_byte;
		if (accept) begin
			case (phase_q)
				PH_HUNT: begin
					phase_d = (rx_ch.rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
				end
				PH_SYNC2: begin
					suma_d = 8'd0;
					sumb_d = 8'd0;
					if (rx_ch.rx_byte == SYNC_SECOND) begin
						phase_d = PH_CLASS;
					end else begin
						phase_d = PH_HUNT;
						class_d = 8'd0;
						id_d = 8'd0;
						len_d = '0;
						pos_d = '0;
						ev = EV_ABANDON;
					end
				end
				PH_CLASS: begin
					class_d = rx_ch.rx_byte;
					suma_d = a_next;
					sumb_d = b_next;
					phase_d = PH_ID;
				end
				PH_ID: begin
					id_d = rx_ch.rx_byte;
					suma_d = a_next;
					sumb_d = b_next;
					phase_d = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					len_d = LEN_W'(rx_ch.rx_byte);
					suma_d = a_next;
					sumb_d = b_next;
					phase_d = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					if (new_len > 16'(MAX_PAYLOAD)) begin
						ev = EV_ABANDON;
						ev_class = class_q;
						ev_id = id_q;
						phase_d = PH_HUNT;
						class_d = 8'd0;
						id_d = 8'd0;
						len_d = '0;
						pos_d = '0;
						suma_d = 8'd0;
						sumb_d = 8'd0;
					end else begin
						len_d = new_len[LEN_W-1:0];
						pos_d = '0;
						suma_d = a_next;
						sumb_d = b_next;
						phase_d = (new_len == 16'd0) ? PH_CK_A : PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					wr.en = 1'b1;
					pos_d = pos_inc;
					suma_d = a_next;
					sumb_d = b_next;
					if (pos_inc >= len_q) begin
						phase_d = PH_CK_A;
					end
				end
				PH_CK_A: begin
					if (rx_ch.rx_byte == suma_q) begin
						phase_d = PH_CK_B;
					end else begin
						ev = EV_CKFAIL;
						ev_class = class_q;
						ev_id = id_q;
						phase_d = PH_HUNT;
						class_d = 8'd0;
						id_d = 8'd0;
						len_d = '0;
						pos_d = '0;
						suma_d = 8'd0;
						sumb_d = 8'd0;
					end
				end
				PH_CK_B: begin
					ev_class = class_q;
					ev_id = id_q;
					if (rx_ch.rx_byte != sumb_q) begin
						ev = EV_CKFAIL;
					end else if (class_q == SAT_CLASS && id_q == SAT_ID &&
							len_q >= LEN_W'(SAT_HDR_LEN)) begin
						ev = EV_SAT;
						walk_start = 1'b1;
					end else begin
						ev = EV_OTHER;
					end
					phase_d = PH_HUNT;
					class_d = 8'd0;
					id_d = 8'd0;
					len_d = '0;
					pos_d = '0;
					suma_d = 8'd0;
					sumb_d = 8'd0;
				end
				default: begin
					phase_d = PH_HUNT;
					class_d = 8'd0;
					id_d = 8'd0;
					len_d = '0;
					pos_d = '0;
					suma_d = 8'd0;
					sumb_d = 8'd0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			class_q <= 8'd0;
			id_q <= 8'd0;
			len_q <= '0;
			pos_q <= '0;
			suma_q <= 8'd0;
			sumb_q <= 8'd0;
		end else begin
			phase_q <= phase_d;
			class_q <= class_d;
			id_q <= id_d;
			len_q <= len_d;
			pos_q <= pos_d;
			suma_q <= suma_d;
			sumb_q <= sumb_d;
		end
	end

	// A satellite frame's result is held back until the walk has refreshed the summary.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (walk_done) begin
			out_valid_q <= 1'b1;
		end else if (accept) begin
			out_valid_q <= !walk_start;
		end else if (res_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_event_q <= ev;
			out_class_q <= ev_class;
			out_id_q <= ev_id;
		end
	end

	gbfp_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.start     (walk_start),
		.frame_len (len_q),
		.busy      (walk_busy),
		.done      (walk_done),
		.summary   (summary)
	);

	assign res_ch.valid = out_valid_q;
	assign res_ch.event_res = out_event_q;
	assign res_ch.frame_class = out_class_q;
	assign res_ch.frame_id = out_id_q;
	assign res_ch.sat_frames_seen = summary.frames_seen;
	assign res_ch.sats_reported = summary.sats_reported;
	assign res_ch.sats_with_signal = summary.sats_with_signal;
	assign res_ch.best_signal = summary.best_signal;

	a_no_byte_during_walk: assert property (@(posedge clk) disable iff (!arst_n)
		walk_busy |-> !rx_ch.ready)
		else $error("byte taken while the record walk runs");

	a_walk_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		walk_start |=> walk_busy && !res_ch.valid)
		else $error("record walk did not start or a result was shown early");

	a_result_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		walk_done |=> res_ch.valid && res_ch.event_res == EV_SAT)
		else $error("satellite result missing after the walk");

	a_store_write_in_payload: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> accept && phase_q == PH_PAYLOAD)
		else $error("payload store written outside the payload phase");

endmodule
